[rtl/core/sha1_pkg.sv]
// Shared types and constants for the SHA-1 hash engine.
`default_nettype none
package sha1_pkg;

	typedef enum logic [1:0] {
		CMD_ABSORB  = 2'd0,
		CMD_FINISH  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ROUND = 2'd1,
		ST_ADD   = 2'd2,
		ST_EMIT  = 2'd3
	} back_state_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage
`default_nettype wire

[rtl/core/sha1_front.sv]
// Input side: accepts transactions, drops unused commands and queues the rest.
`default_nettype none
module sha1_front import sha1_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   s_tvalid,
	output logic        s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] data_byte
	input  wire logic [1:0] s_tuser,  // [1:0] command
	output logic        entry_valid,
	output entry_t      entry,
	input  wire logic   entry_pop
);

	entry_t                q_mem [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;
	logic                  push;
	logic                  pop;

	assign s_tready    = (count_q != (QPTR_W+1)'(QDEPTH));
	assign push        = s_tvalid && s_tready && (cmd_t'(s_tuser) != CMD_UNUSED);
	assign entry_valid = (count_q != '0);
	assign pop         = entry_pop && entry_valid;
	assign entry       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{cmd: cmd_t'(s_tuser), data_byte: s_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/sha1_back.sv]
// Execution side: block buffer, 80-round compression, padding and digest output.
`default_nettype none
module sha1_back import sha1_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   entry_valid,
	input  entry_t      entry,
	output logic        entry_pop,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output logic [31:0] m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	back_state_t st_q, st_nxt;
	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [63:0] cnt_q;
	logic [5:0]  fill_q;
	logic        fin_q;
	logic        second_q;
	logic [2:0]  emit_idx_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	logic        out_free;
	logic        emit_load;
	logic        is_absorb;
	logic        is_finish;
	logic        is_restart;
	logic        two_blocks;
	logic [3:0]  wi;
	logic [31:0] f, k, t, sched;
	logic [31:0] put_data;
	logic [31:0] sum [5];
	logic [7:0]  put_byte;

	assign out_free   = !out_valid_q || m_tready;
	assign is_absorb  = (entry.cmd == CMD_ABSORB);
	assign is_finish  = (entry.cmd == CMD_FINISH);
	assign is_restart = (entry.cmd == CMD_RESTART);
	assign two_blocks = (fill_q[5:3] == 3'b111);
	assign wi         = fill_q[5:2];
	assign put_byte   = is_absorb ? entry.data_byte : PAD_BYTE;

	// Byte goes in big-endian order; bytes below it in the word are cleared.
	always_comb begin
		case (fill_q[1:0])
			2'd0:    put_data = {put_byte, 24'h0};
			2'd1:    put_data = {w_q[wi][31:24], put_byte, 16'h0};
			2'd2:    put_data = {w_q[wi][31:16], put_byte, 8'h0};
			default: put_data = {w_q[wi][31:8], put_byte};
		endcase
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + k;
		sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		sched = {sched[30:0], sched[31]};
	end

	assign sum[0] = h_q[0] + a_q;
	assign sum[1] = h_q[1] + b_q;
	assign sum[2] = h_q[2] + c_q;
	assign sum[3] = h_q[3] + d_q;
	assign sum[4] = h_q[4] + e_q;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (entry_valid && ((is_absorb && fill_q == 6'd63) || is_finish)) begin
					st_nxt = ST_ROUND;
				end
			end
			ST_ROUND: if (rnd_q == LAST_ROUND) st_nxt = ST_ADD;
			ST_ADD: begin
				if (second_q) st_nxt = ST_ROUND;
				else if (fin_q) st_nxt = ST_EMIT;
				else st_nxt = ST_IDLE;
			end
			ST_EMIT: if (out_free && emit_idx_q == LAST_WORD_IDX) st_nxt = ST_IDLE;
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		entry_pop = 1'b0;
		emit_load = 1'b0;
		unique case (st_q)
			ST_IDLE:  entry_pop = entry_valid;
			ST_EMIT:  emit_load = out_free;
			default: begin
				entry_pop = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	// Block buffer and working variables carry no reset.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && entry_valid) begin
			if (is_absorb) begin
				w_q[wi] <= put_data;
			end else if (is_finish) begin
				for (int i = 0; i < 16; i++) begin
					if (4'(i) == wi) begin
						w_q[i] <= put_data;
					end else if (4'(i) > wi) begin
						if (i == 14 && !two_blocks) w_q[i] <= cnt_q[63:32];
						else if (i == 15 && !two_blocks) w_q[i] <= cnt_q[31:0];
						else w_q[i] <= '0;
					end
				end
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (st_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= sched;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else if (st_q == ST_ADD) begin
			for (int i = 0; i < 14; i++) w_q[i] <= '0;
			w_q[14] <= cnt_q[63:32];
			w_q[15] <= cnt_q[31:0];
			a_q <= sum[0];
			b_q <= sum[1];
			c_q <= sum[2];
			d_q <= sum[3];
			e_q <= sum[4];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q <= h_q[emit_idx_q];
			out_idx_q  <= emit_idx_q;
			out_last_q <= (emit_idx_q == LAST_WORD_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			h_q         <= IV;
			rnd_q       <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			fin_q       <= 1'b0;
			second_q    <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (emit_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (entry_valid) begin
						if (is_absorb) begin
							cnt_q  <= cnt_q + 64'd8;
							fill_q <= fill_q + 1'b1;
							fin_q  <= 1'b0;
							second_q <= 1'b0;
						end else if (is_finish) begin
							fin_q    <= 1'b1;
							second_q <= two_blocks;
							emit_idx_q <= '0;
						end else if (is_restart) begin
							h_q    <= IV;
							cnt_q  <= '0;
							fill_q <= '0;
						end
					end
				end
				ST_ROUND: rnd_q <= rnd_q + 1'b1;
				ST_ADD: begin
					rnd_q    <= '0;
					second_q <= 1'b0;
					h_q      <= sum;
				end
				ST_EMIT: begin
					if (out_free) begin
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_idx_q == LAST_WORD_IDX) begin
							h_q    <= IV;
							cnt_q  <= '0;
							fill_q <= '0;
							fin_q  <= 1'b0;
						end
					end
				end
				default: rnd_q <= '0;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tuser  = out_idx_q;
	assign m_tlast  = out_last_q;

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ROUND |-> rnd_q <= LAST_ROUND)
		else $error("round counter ran past the last round");

	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ROUND && rnd_q == LAST_ROUND |=> st_q == ST_ADD)
		else $error("compression did not end in the add step");

	a_last_marks_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_idx_q == LAST_WORD_IDX)))
		else $error("last flag does not match the final digest word");

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		entry_pop |-> st_q == ST_IDLE)
		else $error("queue popped while compression or output is busy");

endmodule
`default_nettype wire

[rtl/core/sha1_hash_engine.sv]
// Top level of the SHA-1 hash engine: input queue feeding the compression core.
// An absorb transaction is written straight into the block buffer; the 64th byte of a block
// also starts the 80 rounds and the final add, run in turn on the single round unit.
// A finish compresses one or two padded blocks and then gives 5 output
// transactions, one per cycle when the sink is ready. A 4-entry queue decouples input.
// Reset loads the standard initial value and clears the bit and byte counts.
`default_nettype none
module sha1_hash_engine import sha1_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic [1:0]  s_tuser,  // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] digest_word
	output logic [2:0]       m_tuser,  // [2:0] word_index
	output logic             m_tlast
);

	logic   entry_valid;
	entry_t entry;
	logic   entry_pop;

	sha1_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.entry_valid (entry_valid),
		.entry       (entry),
		.entry_pop   (entry_pop)
	);

	sha1_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry       (entry),
		.entry_pop   (entry_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the SHA-1 hash engine with a built-in digest predictor.
module tb_top;
	import sha1_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	logic [31:0]  hv [5];
	logic [31:0]  blk [16];
	logic [63:0]  msg_bits;
	logic [5:0]   held;
	digest_beat_t digest_q [$];
	int           mismatches;
	int           idle_cycles;
	bit           finished;

	sha1_hash_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++) w[r] = blk[r];
		for (int r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3]; e = hv[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rol(a, 5) + f + e + w[r] + k;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d; hv[4] += e;
	endtask

	task automatic new_message();
		for (int i = 0; i < 5; i++) hv[i] = IV[i];
		msg_bits = '0;
		held = '0;
	endtask

	// Bytes land big-endian; the first byte of a word clears the rest of it.
	task automatic place_byte(logic [5:0] pos, logic [7:0] v);
		int wi, k;
		logic [31:0] keep;
		wi = pos >> 2;
		k = pos & 3;
		keep = (k == 0) ? 32'h0 : (blk[wi] & ~(32'hFFFF_FFFF >> (8 * k)));
		blk[wi] = keep | (32'(v) << (8 * (3 - k)));
	endtask

	task automatic predict_hash(cmd_t cmd, logic [7:0] b);
		digest_beat_t beat;
		case (cmd)
			CMD_ABSORB: begin
				place_byte(held, b);
				msg_bits += 64'd8;
				held++;
				if (held == 0) compress();
			end
			CMD_RESTART: new_message();
			CMD_FINISH: begin
				place_byte(held, PAD_BYTE);
				for (int i = (held >> 2) + 1; i < 16; i++) blk[i] = '0;
				if (held > 55) begin
					compress();
					for (int i = 0; i < 16; i++) blk[i] = '0;
				end
				blk[14] = msg_bits[63:32];
				blk[15] = msg_bits[31:0];
				compress();
				for (int i = 0; i < 5; i++) begin
					beat.word = hv[i];
					beat.idx = 3'(i);
					beat.last = (i == LAST_WORD_IDX);
					digest_q.push_back(beat);
				end
				new_message();
			end
			default: ;
		endcase
	endtask

	// Valid drops only when a gap follows, so back-to-back transactions keep it high.
	task automatic send_item(cmd_t cmd, logic [7:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_hash(cmd, b);
	endtask

	task automatic absorb_random(int n);
		for (int i = 0; i < n; i++) send_item(CMD_ABSORB, 8'($urandom));
	endtask

	task automatic test_directed();
		send_item(CMD_FINISH, 8'hFF);      // empty message
		send_item(CMD_ABSORB, 8'h00);
		send_item(CMD_ABSORB, 8'hFF);
		send_item(CMD_UNUSED, 8'hA5);      // ignored command
		send_item(CMD_ABSORB, 8'h55);
		send_item(CMD_FINISH, 8'h00);
		send_item(CMD_ABSORB, 8'hAA);
		send_item(CMD_RESTART, 8'h7E);     // drops the pending byte
		send_item(CMD_ABSORB, 8'h61);
		send_item(CMD_ABSORB, 8'h62);
		send_item(CMD_ABSORB, 8'h63);
		send_item(CMD_FINISH, 8'h00);
	endtask

	// A full block, then a tail long enough to need a second padded block.
	task automatic test_pad_boundaries();
		int lens [1] = '{120};
		foreach (lens[i]) begin
			absorb_random(lens[i]);
			send_item(CMD_FINISH, 8'($urandom));
		end
	endtask

	task automatic test_random_messages();
		int r;
		for (int m = 0; m < 8; m++) begin
			absorb_random($urandom_range(0, 5));
			r = $urandom_range(0, 9);
			if (r == 0) send_item(CMD_RESTART, 8'($urandom));
			else if (r == 1) send_item(CMD_UNUSED, 8'($urandom));
			send_item(CMD_FINISH, 8'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected digest word %h", m_tdata);
			end else begin
				digest_beat_t exp_beat;
				exp_beat = digest_q.pop_front();
				if (m_tdata !== exp_beat.word || m_tuser !== exp_beat.idx ||
					m_tlast !== exp_beat.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							exp_beat.word, exp_beat.idx, exp_beat.last,
							m_tdata, m_tuser, m_tlast);
				end
			end
		end
	end

	// Random sink stalls, with occasional stretches of steady readiness.
	int stall_left;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= gap_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000 && !finished) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = CMD_ABSORB;
		m_tready = 0;
		stall_left = 0;
		mismatches = 0;
		idle_cycles = 0;
		finished = 0;
		for (int i = 0; i < 16; i++) blk[i] = '0;
		new_message();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pad_boundaries();
		test_random_messages();
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		finished = 1;
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

[sha1_hash_engine.f]
rtl/core/sha1_pkg.sv
rtl/core/sha1_front.sv
rtl/core/sha1_back.sv
rtl/core/sha1_hash_engine.sv
verif/tb_top.sv
